@@ src/sbfc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbfc_pkg: shared types and constants of the size bounded FIFO cache
// Result kinds, controller states, fixed field widths and the result
// record passed from the controller to the output stage.
// ----------------------------------------------------------------------------
package sbfc_pkg;

   // fixed field widths of the stream channels
   localparam int KEY_W       = 64;
   localparam int BYTES_W     = 32;
   localparam int SLOT_W      = 4;
   localparam int REQ_TDATA_W = KEY_W + BYTES_W;                        // 96
   localparam int RSP_FIELD_W = 1 + SLOT_W + KEY_W + BYTES_W + BYTES_W; // 133
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;           // 136

   localparam logic [BYTES_W-1:0] BUDGET_RESET = 32'd1048576;

   // request action carried in req_tuser
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_EVICT  = 2'd1,
      KIND_INSERT = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_CHECK,
      ST_EVICT,
      ST_FINAL
   } state_type;

   typedef struct packed {
      kind_type             kind;
      logic                 hit;
      logic [SLOT_W-1:0]    slot;
      logic [KEY_W-1:0]     evicted_key;
      logic [BYTES_W-1:0]   evicted_bytes;
      logic [BYTES_W-1:0]   total_bytes;
      logic                 last;
   } res_type;

endpackage
`default_nettype wire

@@ src/sbfc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbfc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module sbfc_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ src/sbfc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbfc_ctrl: directory controller of the size bounded FIFO cache
// Keeps the ring pointers and byte total, scans the entry RAM for lookups,
// evicts oldest entries one per result and appends inserted entries.
// ----------------------------------------------------------------------------
module sbfc_ctrl #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request side
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_action,
   input  wire logic [sbfc_pkg::KEY_W-1:0]   req_key,
   input  wire logic [sbfc_pkg::BYTES_W-1:0] req_bytes,
   input  wire logic [sbfc_pkg::BYTES_W-1:0] budget,
   // result side
   output logic                              res_valid,
   input  wire logic                         res_ready,
   output sbfc_pkg::res_type                 res,
   // entry RAM, data is {size, key}
   output logic                              ram_we,
   output logic [$clog2(ENTRIES)-1:0]        ram_waddr,
   output logic [KEY_BITS+sbfc_pkg::BYTES_W-1:0] ram_wdata,
   output logic                              ram_re,
   output logic [$clog2(ENTRIES)-1:0]        ram_raddr,
   input  wire logic [KEY_BITS+sbfc_pkg::BYTES_W-1:0] ram_rdata
);
   import sbfc_pkg::*;

   localparam int PTR_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W = PTR_W + 1;

   state_type            state_ff, state_in;
   logic [PTR_W-1:0]     oldest_ff, oldest_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [BYTES_W-1:0]   total_ff, total_in;
   logic [PTR_W-1:0]     scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;
   kind_type             fin_kind_ff, fin_kind_in;
   logic                 fin_hit_ff, fin_hit_in;
   logic [PTR_W-1:0]     fin_slot_ff, fin_slot_in;

   logic [BYTES_W:0]     sum_w;
   logic                 over_budget;
   logic                 store_full;
   logic [PTR_W-1:0]     oldest_next;
   logic [PTR_W-1:0]     scan_next;
   logic [IDX_W-1:0]     newest_w;
   logic [PTR_W-1:0]     newest_slot;
   logic                 scan_done;
   logic [KEY_BITS-1:0]  rd_key;
   logic [BYTES_W-1:0]   rd_bytes;

   // widen or narrow a slot index to the result slot field
   function automatic logic [SLOT_W-1:0] to_slot(input logic [PTR_W-1:0] idx);
      logic [SLOT_W+PTR_W-1:0] ext;
      ext = {{SLOT_W{1'b0}}, idx};
      return ext[SLOT_W-1:0];
   endfunction

   // zero-extend a stored key to the result key field
   function automatic logic [KEY_W-1:0] to_key(input logic [KEY_BITS-1:0] k);
      logic [KEY_W+KEY_BITS-1:0] ext;
      ext = {{KEY_W{1'b0}}, k};
      return ext[KEY_W-1:0];
   endfunction

   // datapath helpers
   assign sum_w       = {1'b0, total_ff} + {1'b0, bytes_ff};
   assign over_budget = sum_w > {1'b0, budget};
   assign store_full  = count_ff == CNT_W'(ENTRIES);
   assign oldest_next = (oldest_ff == PTR_W'(ENTRIES - 1)) ? '0 : oldest_ff + PTR_W'(1);
   assign scan_next   = (scan_slot_ff == PTR_W'(ENTRIES - 1)) ? '0 : scan_slot_ff + PTR_W'(1);
   assign newest_w    = IDX_W'(oldest_ff) + IDX_W'(count_ff);
   assign newest_slot = (newest_w >= IDX_W'(ENTRIES)) ?
                        PTR_W'(newest_w - IDX_W'(ENTRIES)) : PTR_W'(newest_w);
   assign scan_done   = (scan_idx_ff + CNT_W'(1)) == count_ff;
   assign rd_key      = ram_rdata[KEY_BITS-1:0];
   assign rd_bytes    = ram_rdata[KEY_BITS +: BYTES_W];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         oldest_ff <= '0;
         count_ff  <= '0;
         total_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
      end
   end

   // item and scan registers
   always_ff @(posedge clock) begin
      scan_slot_ff <= scan_slot_in;
      scan_idx_ff  <= scan_idx_in;
      key_ff       <= key_in;
      bytes_ff     <= bytes_in;
      fin_kind_ff  <= fin_kind_in;
      fin_hit_ff   <= fin_hit_in;
      fin_slot_ff  <= fin_slot_in;
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      scan_slot_in = scan_slot_ff;
      scan_idx_in  = scan_idx_ff;
      key_in       = key_ff;
      bytes_in     = bytes_ff;
      fin_kind_in  = fin_kind_ff;
      fin_hit_in   = fin_hit_ff;
      fin_slot_in  = fin_slot_ff;

      req_ready  = 1'b0;
      res_valid  = 1'b0;
      res        = '0;
      res.total_bytes = total_ff;
      ram_we     = 1'b0;
      ram_waddr  = fin_slot_ff;
      ram_wdata  = {bytes_ff, key_ff};
      ram_re     = 1'b0;
      ram_raddr  = oldest_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in      = req_key[KEY_BITS-1:0];
               bytes_in    = req_bytes;
               fin_hit_in  = 1'b0;
               fin_slot_in = '0;
               if (req_action == ACT_LOOKUP) begin
                  fin_kind_in = KIND_LOOKUP;
                  if (count_ff == '0) begin
                     state_in = ST_FINAL;
                  end else begin
                     // start the scan at the oldest entry
                     ram_re       = 1'b1;
                     scan_slot_in = oldest_ff;
                     scan_idx_in  = '0;
                     state_in     = ST_LOOK;
                  end
               end else if (req_bytes > budget) begin
                  fin_kind_in = KIND_REJECT;
                  state_in    = ST_FINAL;
               end else begin
                  fin_kind_in = KIND_INSERT;
                  state_in    = ST_CHECK;
               end
            end
         end

         ST_LOOK: begin
            // compare the entry read last cycle, fetch the next one
            if (rd_key == key_ff) begin
               fin_hit_in  = 1'b1;
               fin_slot_in = scan_slot_ff;
               state_in    = ST_FINAL;
            end else if (scan_done) begin
               state_in = ST_FINAL;
            end else begin
               ram_re       = 1'b1;
               ram_raddr    = scan_next;
               scan_slot_in = scan_next;
               scan_idx_in  = scan_idx_ff + CNT_W'(1);
            end
         end

         ST_CHECK: begin
            if ((count_ff != '0 && over_budget) || store_full) begin
               // fetch the oldest entry for eviction
               ram_re   = 1'b1;
               state_in = ST_EVICT;
            end else begin
               fin_slot_in = newest_slot;
               state_in    = ST_FINAL;
            end
         end

         ST_EVICT: begin
            res_valid         = 1'b1;
            res.kind          = KIND_EVICT;
            res.slot          = to_slot(oldest_ff);
            res.evicted_key   = to_key(rd_key);
            res.evicted_bytes = rd_bytes;
            res.total_bytes   = total_ff - rd_bytes;
            if (res_ready) begin
               total_in  = total_ff - rd_bytes;
               oldest_in = oldest_next;
               count_in  = count_ff - CNT_W'(1);
               state_in  = ST_CHECK;
            end
         end

         ST_FINAL: begin
            res_valid = 1'b1;
            res.kind  = fin_kind_ff;
            res.hit   = fin_hit_ff;
            res.slot  = to_slot(fin_slot_ff);
            res.last  = 1'b1;
            if (fin_kind_ff == KIND_INSERT) begin
               res.total_bytes = sum_w[BYTES_W-1:0];
            end
            if (res_ready) begin
               // append the new entry as the transaction leaves
               if (fin_kind_ff == KIND_INSERT) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  total_in = sum_w[BYTES_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ src/size_bounded_fifo_cache.sv @@
`default_nettype none
// Operation: a lookup scans the stored entries from the oldest until a hit or
//   the newest; an insert first evicts oldest entries while over budget or full.
// Throughput: one request at a time; the scan rate is set by the single
//   read port of the entry RAM, one entry per cycle.
// Reset: synchronous; empties the directory and loads the byte budget with
//   1048576. Entry RAM contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// size_bounded_fifo_cache: FIFO cache directory under a byte budget
// Stream request/response top level with the entry RAM, the directory
// controller, the budget register and the response output register.
// ----------------------------------------------------------------------------
module size_bounded_fifo_cache #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sbfc_pkg::REQ_TDATA_W-1:0]  req_tdata,  // key[63:0], item_bytes[95:64]
   input  wire logic                              req_tuser,  // action[0]
   // response channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sbfc_pkg::RSP_TDATA_W-1:0]       rsp_tdata,  // hit[0], slot[4:1],
                                                  // evicted_key[68:5], evicted_bytes[100:69],
                                                  // total_bytes[132:101], zero[135:133]
   output logic [1:0]                             rsp_tuser,  // kind[1:0]
   output logic                                   rsp_tlast,
   // configuration
   input  wire logic                              csr_we,
   input  wire logic [sbfc_pkg::BYTES_W-1:0]      csr_wdata   // byte_budget
);
   import sbfc_pkg::*;

   localparam int PTR_W = $clog2(ENTRIES);
   localparam int RAM_W = KEY_BITS + BYTES_W;

   logic [BYTES_W-1:0] budget_ff;
   logic               res_valid;
   logic               res_ready;
   res_type            res;
   res_type            rsp_ff;
   logic               rsp_valid_ff;
   logic               ram_we;
   logic [PTR_W-1:0]   ram_waddr;
   logic [RAM_W-1:0]   ram_wdata;
   logic               ram_re;
   logic [PTR_W-1:0]   ram_raddr;
   logic [RAM_W-1:0]   ram_rdata;

   // byte budget register
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else if (csr_we) begin
         budget_ff <= csr_wdata;
      end
   end

   sbfc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   sbfc_ctrl #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_key    (req_tdata[KEY_W-1:0]),
      .req_bytes  (req_tdata[KEY_W +: BYTES_W]),
      .budget     (budget_ff),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   // output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   // drive the response channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}},
                        rsp_ff.total_bytes, rsp_ff.evicted_bytes,
                        rsp_ff.evicted_key, rsp_ff.slot, rsp_ff.hit};

endmodule
`default_nettype wire

@@ src/sbfc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbfc_checker: port-level assertions for the size bounded FIFO cache
// Watches the request and response channels and checks result framing.
// ----------------------------------------------------------------------------
module sbfc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [sbfc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic [1:0]                        rsp_tuser,
   input wire logic                              rsp_tlast
);
   import sbfc_pkg::*;

   // stalled response transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // one request at a time: no back-to-back accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one in flight");

   // evictions are never last, every other kind always is
   a_last_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_EVICT)))
      else $error("tlast does not match result kind");

   // non-eviction results carry zero evicted fields
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_EVICT |-> rsp_tdata[100:5] == '0)
      else $error("evicted fields set on non-eviction result");

   // hit only on lookup answers
   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tuser == KIND_LOOKUP)
      else $error("hit flag on non-lookup result");

endmodule

bind size_bounded_fifo_cache sbfc_checker u_sbfc_checker (.*);
`default_nettype wire

@@ test/sbfc_result_checker.sv @@
// ----------------------------------------------------------------------------
// sbfc_result_checker: response checker for the size bounded FIFO cache
// Watches the request, response and CSR channels, keeps its own copy of the
// directory (ring of keys and sizes, byte total, byte budget), works out the
// responses of every accepted request and compares each accepted response
// field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module sbfc_result_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [sbfc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                              req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [sbfc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic [1:0]                        rsp_tuser,
   input  wire logic                              rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [sbfc_pkg::BYTES_W-1:0]      csr_wdata,
   output int                                     fail_count,
   output int                                     pending_results
);
   import sbfc_pkg::*;

   localparam int ENTRIES    = 16;

   // shadow directory
   logic [KEY_W-1:0]   held_key   [ENTRIES];
   logic [BYTES_W-1:0] held_bytes [ENTRIES];
   int unsigned        oldest_slot  = 0;
   int unsigned        held_count   = 0;
   logic [BYTES_W-1:0] held_total   = '0;
   logic [BYTES_W-1:0] byte_budget  = BUDGET_RESET;

   res_type            awaited_responses[$];
   int                 mismatches      = 0;
   int                 response_number = 0;

   // print one line per mismatch and count it
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: response %0d mismatch on %s: got %h, expected %h",
               $time, response_number, what, got, want);
      mismatches++;
   endtask

   function automatic res_type make_response(input kind_type kind, input logic hit,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [KEY_W-1:0] ekey,
                                             input logic [BYTES_W-1:0] ebytes,
                                             input logic last);
      res_type r;
      r.kind          = kind;
      r.hit           = hit;
      r.slot          = slot;
      r.evicted_key   = ekey;
      r.evicted_bytes = ebytes;
      r.total_bytes   = held_total;
      r.last          = last;
      return r;
   endfunction

   // drop the oldest entry and queue its eviction response
   task automatic evict_oldest();
      int unsigned s;
      s = oldest_slot;
      held_total = held_total - held_bytes[s];
      awaited_responses.push_back(make_response(KIND_EVICT, 1'b0, SLOT_W'(s),
                                                held_key[s], held_bytes[s], 1'b0));
      oldest_slot = (s + 1) % ENTRIES;
      held_count--;
   endtask

   // work out every response of one accepted request transaction
   task automatic model_cache_request(input logic action, input logic [KEY_W-1:0] key,
                                      input logic [BYTES_W-1:0] item_bytes);
      int unsigned        s;
      logic               found;
      logic [SLOT_W-1:0]  hit_slot;
      if (action == ACT_LOOKUP) begin
         found    = 1'b0;
         hit_slot = '0;
         // scan from oldest to newest; the oldest copy wins
         for (int i = 0; i < held_count; i++) begin
            s = (oldest_slot + i) % ENTRIES;
            if (!found && held_key[s] == key) begin
               found    = 1'b1;
               hit_slot = SLOT_W'(s);
            end
         end
         awaited_responses.push_back(make_response(KIND_LOOKUP, found, hit_slot,
                                                   '0, '0, 1'b1));
      end else if (item_bytes > byte_budget) begin
         awaited_responses.push_back(make_response(KIND_REJECT, 1'b0, '0, '0, '0, 1'b1));
      end else begin
         // make room under the budget, then make room in the store
         while (held_count > 0 &&
                (33'(held_total) + 33'(item_bytes)) > 33'(byte_budget))
            evict_oldest();
         if (held_count >= ENTRIES)
            evict_oldest();
         s = (oldest_slot + held_count) % ENTRIES;
         held_key[s]   = key;
         held_bytes[s] = item_bytes;
         held_count++;
         held_total = held_total + item_bytes;
         awaited_responses.push_back(make_response(KIND_INSERT, 1'b0, SLOT_W'(s),
                                                   '0, '0, 1'b1));
      end
   endtask

   // compare one accepted response transaction with the oldest expectation
   task automatic check_response();
      res_type want;
      response_number++;
      if (awaited_responses.size() == 0) begin
         report_mismatch("unexpected response", {62'd0, rsp_tuser}, '0);
         return;
      end
      want = awaited_responses.pop_front();
      if (rsp_tuser != want.kind)
         report_mismatch("kind", 64'(rsp_tuser), 64'(want.kind));
      if (rsp_tdata[0] != want.hit)
         report_mismatch("hit", 64'(rsp_tdata[0]), 64'(want.hit));
      if (rsp_tdata[4:1] != want.slot)
         report_mismatch("slot", 64'(rsp_tdata[4:1]), 64'(want.slot));
      if (rsp_tdata[68:5] != want.evicted_key)
         report_mismatch("evicted_key", rsp_tdata[68:5], want.evicted_key);
      if (rsp_tdata[100:69] != want.evicted_bytes)
         report_mismatch("evicted_bytes", 64'(rsp_tdata[100:69]),
                         64'(want.evicted_bytes));
      if (rsp_tdata[132:101] != want.total_bytes)
         report_mismatch("total_bytes", 64'(rsp_tdata[132:101]),
                         64'(want.total_bytes));
      if (rsp_tdata[RSP_TDATA_W-1:133] != '0)
         report_mismatch("padding", 64'(rsp_tdata[RSP_TDATA_W-1:133]), '0);
      if (rsp_tlast != want.last)
         report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
   endtask

   // sample all channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         awaited_responses.delete();
         oldest_slot = 0;
         held_count  = 0;
         held_total  = '0;
         byte_budget = BUDGET_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_response();
         if (csr_we)
            byte_budget = csr_wdata;
         if (req_tvalid && req_tready)
            model_cache_request(req_tuser, req_tdata[KEY_W-1:0],
                                req_tdata[KEY_W+BYTES_W-1:KEY_W]);
      end
      fail_count      <= mismatches;
      pending_results <= awaited_responses.size();
   end

endmodule

@@ test/tb_size_bounded_fifo_cache.sv @@
// ----------------------------------------------------------------------------
// tb_size_bounded_fifo_cache: testbench of the size bounded FIFO cache
// Drives lookups and inserts through the request stream in bursts, stalls
// the response stream on a changing pattern, rewrites the byte budget
// between phases and leaves response checking to sbfc_result_checker.
// ----------------------------------------------------------------------------
module tb_size_bounded_fifo_cache;
   import sbfc_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_ITEMS = 92;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;   // key[63:0], item_bytes[95:64]
   logic                    req_tuser  = 1'b0; // action[0]
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;         // hit[0], slot[4:1], evicted_key[68:5],
                                               // evicted_bytes[100:69],
                                               // total_bytes[132:101], zero[135:133]
   logic [1:0]              rsp_tuser;         // kind[1:0]
   logic                    rsp_tlast;
   logic                    csr_we     = 1'b0;
   logic [BYTES_W-1:0]      csr_wdata  = '0;

   int                      fail_count;
   int                      pending_results;

   int                      burst_left     = 0;
   logic [BYTES_W-1:0]      budget_now     = BUDGET_RESET;
   logic [KEY_W-1:0]        key_pool[$];
   logic                    long_hold_req  = 1'b0;
   logic                    long_hold_done = 1'b0;
   int                      rx_hold_left   = 0;
   logic [7:0]              rx_cycle       = '0;
   int                      idle_cycles    = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   size_bounded_fifo_cache i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   sbfc_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // stall the response side: one long hold on request, else a rotating pattern
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1'b1;
      if (rx_hold_left != 0) begin
         rsp_tready   <= 1'b0;
         rx_hold_left <= rx_hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
         rsp_tready     <= 1'b0;
         rx_hold_left   <= 400;
         long_hold_done <= 1'b1;
      end else begin
         case (rx_cycle[7:6])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= (rx_cycle % 3 == 0);
            2'd2:    rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // end the run when no transaction completes for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // offer one request transaction, opening a new burst after a random gap
   task automatic send_request(input logic action, input logic [KEY_W-1:0] key,
                               input logic [BYTES_W-1:0] item_bytes);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {item_bytes, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // hold the sender until every response is in and the block is idle
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_budget(input logic [BYTES_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly sizes that fit, some up to the budget, some too big, some full range
   function automatic logic [BYTES_W-1:0] pick_item_bytes(input logic [BYTES_W-1:0] budget);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 6)
         return '0;
      if (r < 66)
         return $urandom_range(0, budget / 8);
      if (r < 84)
         return $urandom_range(0, budget);
      if (r < 90 && budget != 32'hFFFF_FFFF)
         return $urandom_range(budget + 1, 32'hFFFF_FFFF);
      return $urandom();
   endfunction

   // random lookups and inserts; lookups mostly target recently inserted keys
   task automatic run_random_phase(input int count);
      logic               action;
      logic [KEY_W-1:0]   key;
      logic [BYTES_W-1:0] item_bytes;
      int unsigned        r;
      for (int n = 0; n < count; n++) begin
         action = ($urandom_range(0, 99) < 60) ? ACT_INSERT : ACT_LOOKUP;
         r      = $urandom_range(0, 99);
         if (r < 8)
            key = ($urandom_range(0, 1) != 0) ? '1 : '0;
         else if (key_pool.size() != 0 && r < ((action == ACT_INSERT) ? 18 : 70))
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
         else
            key = {$urandom(), $urandom()};
         item_bytes = pick_item_bytes(budget_now);
         send_request(action, key, item_bytes);
         if (action == ACT_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > 24)
               void'(key_pool.pop_front());
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset budget: miss on empty store, zero size, exact fit, too big
      send_request(ACT_LOOKUP, 64'd0, 32'd0);
      send_request(ACT_INSERT, 64'd0, 32'd0);
      send_request(ACT_INSERT, '1, 32'd1048576);
      send_request(ACT_INSERT, 64'd5, 32'hFFFF_FFFF);
      send_request(ACT_INSERT, 64'd6, 32'd1048577);
      send_request(ACT_LOOKUP, '1, 32'hFFFF_FFFF);
      send_request(ACT_LOOKUP, 64'd0, 32'd0);
      // budget eviction of two entries, then a duplicate key (oldest copy wins)
      send_request(ACT_INSERT, 64'd5, 32'd100);
      send_request(ACT_INSERT, 64'd5, 32'd7);
      send_request(ACT_LOOKUP, 64'd5, 32'd0);
      send_request(ACT_LOOKUP, 64'hAAAA_5555_AAAA_5555, 32'd0);

      // zero budget: only zero-size items get in
      drain_block();
      write_budget(32'd0);
      send_request(ACT_INSERT, 64'd7, 32'd0);
      send_request(ACT_INSERT, 64'd8, 32'd1);

      // full-range budget: largest item fits, any more evicts it
      drain_block();
      write_budget(32'hFFFF_FFFF);
      send_request(ACT_INSERT, 64'd9, 32'hFFFF_FFFF);
      send_request(ACT_INSERT, 64'd10, 32'd1);
      send_request(ACT_INSERT, 64'd11, 32'hF000_0000);

      // budget lowered below the held total
      drain_block();
      write_budget(32'd1000);
      send_request(ACT_INSERT, 64'd12, 32'd10);
      send_request(ACT_LOOKUP, 64'd11, 32'd0);

      // random phases, one budget setting each
      for (int p = 0; p < 5; p++) begin
         drain_block();
         case (p)
            0:       budget_now = 32'd2000;
            1:       budget_now = 32'hFFFF_FFFF;
            2:       budget_now = $urandom();
            3:       budget_now = 32'd0;
            default: budget_now = BUDGET_RESET;
         endcase
         if (p == 1)
            long_hold_req <= 1'b1;
         write_budget(budget_now);
         run_random_phase(PHASE_ITEMS);
      end

      drain_block();
      if (fail_count == 0 && pending_results == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
